@@ src/mcbq_pkg.sv @@
// Shared constants, step codes and control structs for the multichannel biquad.
// No dependencies; used by mcbq_lane, mcbq_merge and multichannel_biquad_tdf2.
`default_nettype none

package mcbq_pkg;

	localparam int LANES          = 4;
	localparam int LANE_W         = 2;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 32;
	localparam int COEF_FRAC_BITS = 29;
	localparam int DELAY_BITS     = SAMPLE_BITS + COEF_BITS;
	localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_Y_BITS     = DELAY_BITS + 1;
	localparam int ACC_BITS       = DELAY_BITS + 2;
	localparam int RND_BITS       = ACC_Y_BITS - COEF_FRAC_BITS;
	localparam int SLOTS          = 5;
	localparam int SLOT_W         = 3;
	localparam int CNT_W          = 3;

	localparam logic signed [ACC_Y_BITS-1:0] ROUND_C =
		{{(ACC_Y_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_COEF  = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_B0  = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_B1  = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_B2  = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_NA1 = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_NA2 = 3'd4;

	// Sequencer steps shared by every lane
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MULB0 = 3'd1;
	localparam logic [2:0] ST_OUT   = 3'd2;
	localparam logic [2:0] ST_ACCZ2 = 3'd3;
	localparam logic [2:0] ST_ACCFB = 3'd4;
	localparam logic [2:0] ST_WRZ1  = 3'd5;
	localparam logic [2:0] ST_WRZ2  = 3'd6;

	typedef struct packed {
		logic       load;
		logic [2:0] step;
	} ctl_t;

	typedef struct packed {
		logic [SLOT_W-1:0]           slot;
		logic signed [COEF_BITS-1:0] value;
	} cwr_t;

endpackage

`default_nettype wire

@@ src/multichannel_biquad_tdf2.sv @@
// Four-lane transposed direct form II biquad: sequencer, lanes and output stage.
// Depends on mcbq_pkg, mcbq_lane and mcbq_merge.
// Frame beat: result registered in the output stage after WRZ2; a new beat is
// taken only in idle, set by the six-step schedule around the one multiplier per lane.
// Coefficient beat: taken only in idle, gives no result.
// Reset clears coefficients and delays to zero and sets the active lane count to 4.
`default_nettype none

module multichannel_biquad_tdf2 (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [2:0]                            cfg_wdata,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  operation,
	input  wire logic signed [mcbq_pkg::SAMPLE_BITS-1:0] sample_0,
	input  wire logic signed [mcbq_pkg::SAMPLE_BITS-1:0] sample_1,
	input  wire logic signed [mcbq_pkg::SAMPLE_BITS-1:0] sample_2,
	input  wire logic signed [mcbq_pkg::SAMPLE_BITS-1:0] sample_3,
	input  wire logic [mcbq_pkg::LANE_W-1:0]           coef_lane,
	input  wire logic [mcbq_pkg::SLOT_W-1:0]           coef_slot,
	input  wire logic signed [mcbq_pkg::COEF_BITS-1:0] coef_value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [mcbq_pkg::SAMPLE_BITS-1:0]    out_0,
	output logic signed [mcbq_pkg::SAMPLE_BITS-1:0]    out_1,
	output logic signed [mcbq_pkg::SAMPLE_BITS-1:0]    out_2,
	output logic signed [mcbq_pkg::SAMPLE_BITS-1:0]    out_3,
	output logic [mcbq_pkg::LANES-1:0]                 clip_mask
);

	logic [2:0]                              active_lanes_q;
	logic [2:0]                              step_q;
	logic                                    accept;
	logic                                    res_ready;
	mcbq_pkg::ctl_t                          ctl;
	mcbq_pkg::cwr_t                          cwr;
	logic signed [mcbq_pkg::SAMPLE_BITS-1:0] samp  [mcbq_pkg::LANES];
	logic signed [mcbq_pkg::SAMPLE_BITS-1:0] y     [mcbq_pkg::LANES];
	logic signed [mcbq_pkg::SAMPLE_BITS-1:0] out_y [mcbq_pkg::LANES];
	logic [mcbq_pkg::LANES-1:0]              clip;

	assign in_ready = (step_q == mcbq_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign ctl.load = accept && (operation == mcbq_pkg::OP_FRAME);
	assign ctl.step = step_q;

	assign cwr.slot  = coef_slot;
	assign cwr.value = coef_value;

	assign samp[0] = sample_0;
	assign samp[1] = sample_1;
	assign samp[2] = sample_2;
	assign samp[3] = sample_3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_lanes_q <= 3'd4;
		else if (cfg_we)
			active_lanes_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mcbq_pkg::ST_IDLE;
		end else begin
			unique case (step_q)
				mcbq_pkg::ST_IDLE:  if (ctl.load) step_q <= mcbq_pkg::ST_MULB0;
				mcbq_pkg::ST_MULB0: step_q <= mcbq_pkg::ST_OUT;
				mcbq_pkg::ST_OUT:   step_q <= mcbq_pkg::ST_ACCZ2;
				mcbq_pkg::ST_ACCZ2: step_q <= mcbq_pkg::ST_ACCFB;
				mcbq_pkg::ST_ACCFB: step_q <= mcbq_pkg::ST_WRZ1;
				mcbq_pkg::ST_WRZ1:  step_q <= mcbq_pkg::ST_WRZ2;
				// hold the last step until the output stage takes the beat
				mcbq_pkg::ST_WRZ2:  if (res_ready) step_q <= mcbq_pkg::ST_IDLE;
				default:            step_q <= mcbq_pkg::ST_IDLE;
			endcase
		end
	end

	for (genvar l = 0; l < mcbq_pkg::LANES; l++) begin : g_lane
		logic lane_active;
		logic lane_we;

		assign lane_active = active_lanes_q > 3'(l);
		assign lane_we     = accept && (operation == mcbq_pkg::OP_COEF)
			&& (coef_lane == mcbq_pkg::LANE_W'(l));

		mcbq_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.active  (lane_active),
			.x       (samp[l]),
			.coef_we (lane_we),
			.cwr     (cwr),
			.y       (y[l]),
			.clip    (clip[l])
		);
	end

	mcbq_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (step_q == mcbq_pkg::ST_WRZ2),
		.res_ready (res_ready),
		.y         (y),
		.clip      (clip),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_y     (out_y),
		.clip_mask (clip_mask)
	);

	assign out_0 = out_y[0];
	assign out_1 = out_y[1];
	assign out_2 = out_y[2];
	assign out_3 = out_y[3];

endmodule

`default_nettype wire

@@ src/mcbq_lane.sv @@
// One biquad lane: coefficient registers, delay registers and one shared multiplier.
// Depends on mcbq_pkg; stepped by the sequencer in multichannel_biquad_tdf2.
`default_nettype none

module mcbq_lane (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire mcbq_pkg::ctl_t                        ctl,
	input  wire logic                                  active,
	input  wire logic signed [mcbq_pkg::SAMPLE_BITS-1:0] x,
	input  wire logic                                  coef_we,
	input  wire mcbq_pkg::cwr_t                        cwr,
	output logic signed [mcbq_pkg::SAMPLE_BITS-1:0]    y,
	output logic                                       clip
);

	logic signed [mcbq_pkg::COEF_BITS-1:0]   coef_q [mcbq_pkg::SLOTS];
	logic signed [mcbq_pkg::DELAY_BITS-1:0]  z1_q;
	logic signed [mcbq_pkg::DELAY_BITS-1:0]  z2_q;
	logic signed [mcbq_pkg::SAMPLE_BITS-1:0] x_q;
	logic signed [mcbq_pkg::SAMPLE_BITS-1:0] y_q;
	logic                                    clip_q;
	logic                                    active_q;
	logic signed [mcbq_pkg::PROD_BITS-1:0]   p_q;
	logic signed [mcbq_pkg::ACC_BITS-1:0]    acc_q;

	logic signed [mcbq_pkg::COEF_BITS-1:0]   mc;
	logic signed [mcbq_pkg::SAMPLE_BITS-1:0] mx;
	logic signed [mcbq_pkg::PROD_BITS-1:0]   prod;
	logic signed [mcbq_pkg::ACC_Y_BITS-1:0]  acc_y;
	logic        [mcbq_pkg::RND_BITS-1:0]    rnd;
	logic                                    y_ok;
	logic signed [mcbq_pkg::SAMPLE_BITS-1:0] y_sat;
	logic signed [mcbq_pkg::ACC_BITS-1:0]    acc_p;
	logic signed [mcbq_pkg::ACC_BITS-1:0]    z2_sum;

	function automatic logic signed [mcbq_pkg::DELAY_BITS-1:0] sat_delay(
		input logic signed [mcbq_pkg::ACC_BITS-1:0] v
	);
		logic [mcbq_pkg::ACC_BITS-mcbq_pkg::DELAY_BITS:0] top;
		top = v[mcbq_pkg::ACC_BITS-1:mcbq_pkg::DELAY_BITS-1];
		if ((&top) || !(|top))
			return v[mcbq_pkg::DELAY_BITS-1:0];
		return {v[mcbq_pkg::ACC_BITS-1], {(mcbq_pkg::DELAY_BITS-1){~v[mcbq_pkg::ACC_BITS-1]}}};
	endfunction

	// Pick multiplier operands for the current step
	always_comb begin
		unique case (ctl.step)
			mcbq_pkg::ST_MULB0: begin
				mc = coef_q[mcbq_pkg::SLOT_B0];
				mx = x_q;
			end
			mcbq_pkg::ST_OUT: begin
				mc = coef_q[mcbq_pkg::SLOT_B1];
				mx = x_q;
			end
			mcbq_pkg::ST_ACCZ2: begin
				mc = coef_q[mcbq_pkg::SLOT_NA1];
				mx = y_q;
			end
			mcbq_pkg::ST_ACCFB: begin
				mc = coef_q[mcbq_pkg::SLOT_B2];
				mx = x_q;
			end
			mcbq_pkg::ST_WRZ1: begin
				mc = coef_q[mcbq_pkg::SLOT_NA2];
				mx = y_q;
			end
			default: begin
				mc = coef_q[mcbq_pkg::SLOT_B0];
				mx = x_q;
			end
		endcase
	end

	assign prod = mc * mx;

	// Round half up, then saturate to the sample range
	assign acc_y = mcbq_pkg::ACC_Y_BITS'(p_q) + mcbq_pkg::ACC_Y_BITS'(z1_q) + mcbq_pkg::ROUND_C;
	assign rnd   = acc_y[mcbq_pkg::ACC_Y_BITS-1:mcbq_pkg::COEF_FRAC_BITS];
	assign y_ok  = (&rnd[mcbq_pkg::RND_BITS-1:mcbq_pkg::SAMPLE_BITS-1])
		|| !(|rnd[mcbq_pkg::RND_BITS-1:mcbq_pkg::SAMPLE_BITS-1]);
	assign y_sat = y_ok ? rnd[mcbq_pkg::SAMPLE_BITS-1:0]
		: {rnd[mcbq_pkg::RND_BITS-1], {(mcbq_pkg::SAMPLE_BITS-1){~rnd[mcbq_pkg::RND_BITS-1]}}};

	assign acc_p  = acc_q + mcbq_pkg::ACC_BITS'(p_q);
	assign z2_sum = acc_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < mcbq_pkg::SLOTS; s++)
				coef_q[s] <= '0;
		end else if (coef_we) begin
			unique case (cwr.slot)
				mcbq_pkg::SLOT_B0:  coef_q[0] <= cwr.value;
				mcbq_pkg::SLOT_B1:  coef_q[1] <= cwr.value;
				mcbq_pkg::SLOT_B2:  coef_q[2] <= cwr.value;
				mcbq_pkg::SLOT_NA1: coef_q[3] <= cwr.value;
				mcbq_pkg::SLOT_NA2: coef_q[4] <= cwr.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q     <= '0;
			z2_q     <= '0;
			active_q <= 1'b0;
			clip_q   <= 1'b0;
		end else begin
			if (ctl.load)
				active_q <= active;
			if (ctl.step == mcbq_pkg::ST_OUT)
				clip_q <= active_q && !y_ok;
			if (ctl.step == mcbq_pkg::ST_WRZ1 && active_q)
				z1_q <= sat_delay(acc_q);
			// Stalled final step rewrites the same value
			if (ctl.step == mcbq_pkg::ST_WRZ2 && active_q)
				z2_q <= sat_delay(z2_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			x_q <= x;
		if (ctl.step == mcbq_pkg::ST_OUT)
			y_q <= active_q ? y_sat : x_q;
		if (ctl.step != mcbq_pkg::ST_IDLE && ctl.step != mcbq_pkg::ST_WRZ2)
			p_q <= prod;
		unique case (ctl.step)
			mcbq_pkg::ST_ACCZ2: acc_q <= mcbq_pkg::ACC_BITS'(p_q) + mcbq_pkg::ACC_BITS'(z2_q);
			mcbq_pkg::ST_ACCFB: acc_q <= acc_p;
			mcbq_pkg::ST_WRZ1:  acc_q <= mcbq_pkg::ACC_BITS'(p_q);
			default: ;
		endcase
	end

	assign y    = y_q;
	assign clip = clip_q;

endmodule

`default_nettype wire

@@ src/mcbq_merge.sv @@
// Output stage: gathers the lane samples and clip flags into one result beat.
// Depends on mcbq_pkg; fed by the mcbq_lane instances in multichannel_biquad_tdf2.
`default_nettype none

module mcbq_merge (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  res_valid,
	output logic                                       res_ready,
	input  wire logic signed [mcbq_pkg::SAMPLE_BITS-1:0] y [mcbq_pkg::LANES],
	input  wire logic [mcbq_pkg::LANES-1:0]            clip,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [mcbq_pkg::SAMPLE_BITS-1:0]    out_y [mcbq_pkg::LANES],
	output logic [mcbq_pkg::LANES-1:0]                 clip_mask
);

	logic                                    out_valid_q;
	logic signed [mcbq_pkg::SAMPLE_BITS-1:0] out_y_q [mcbq_pkg::LANES];
	logic [mcbq_pkg::LANES-1:0]              clip_q;

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			for (int l = 0; l < mcbq_pkg::LANES; l++)
				out_y_q[l] <= y[l];
			clip_q <= clip;
		end
	end

	assign out_valid = out_valid_q;
	assign out_y     = out_y_q;
	assign clip_mask = clip_q;

endmodule

`default_nettype wire
